// File: hdl/csms_pkg.sv
package csms_pkg;

   // Default sizes of the table and of the matrix.
   localparam int DEF_MAX_ENTRIES = 256;
   localparam int DEF_MAX_DIM     = 256;

   // Transaction kinds on the request channel.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   // Reset value of both size registers.
   localparam logic [8:0] DIM_RESET = 9'd256;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               found;
      logic [1:0]         status;
      logic [8:0]         entry_count;
   } rsp_type;

endpackage

// File: hdl/coo_sparse_matrix_store.sv
// An out-of-range or unused transaction goes straight to the result. Otherwise the entries
// are read and compared in row-major order; an insert moves each later entry up by one and
// then writes the new entry; the result is latched once the output register is free.
// Throughput: one transaction at a time; a new request is taken the cycle after the result
// is latched. Reset (synchronous, active high) empties the table, rewinds the load scan and
// sets both size registers to 256; the table memory itself is not cleared.
module coo_sparse_matrix_store #(
   parameter int MAX_ENTRIES = csms_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_DIM     = csms_pkg::DEF_MAX_DIM
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csms_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_wdata
);
   import csms_pkg::*;

   localparam int IW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CW    = $clog2(MAX_DIM);
   localparam int CMP_W = (DIM_W > 9) ? DIM_W : 9;
   localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;

   typedef struct packed {
      logic signed [31:0] val;
      logic [CW-1:0]      r;
      logic [CW-1:0]      c;
   } entry_type;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_CMP = 7'b0000100,
      S_SHIFT_RD = 7'b0001000,
      S_SHIFT_WR = 7'b0010000,
      S_INSERT   = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_UPSERT = 2'd1,
      OP_PROBE  = 2'd2
   } op_type;

   // Table memory with a registered read port.
   entry_type entry_store_ff [MAX_ENTRIES];
   entry_type rdata_ff;
   logic      mem_we;
   logic [IW-1:0] mem_waddr;
   logic [IW-1:0] mem_raddr;
   entry_type mem_wdata;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [CW-1:0]      key_r_ff, key_r_in;
   logic [CW-1:0]      key_c_ff, key_c_in;
   logic signed [31:0] val_ff, val_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [IW-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] rd_ff, rd_in;
   logic               found_ff, found_in;
   logic [1:0]         status_ff, status_in;
   logic [DIM_W-1:0]   scan_row_ff, scan_row_in;
   logic [CW-1:0]      scan_col_ff, scan_col_in;
   logic [8:0]         row_count_ff, row_count_in;
   logic [8:0]         col_count_ff, col_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CMP_W-1:0] rows_eff;
   logic [CMP_W-1:0] cols_eff;
   logic [CMP_W-1:0] req_row_ext;
   logic [CMP_W-1:0] req_col_ext;
   logic [CMP_W-1:0] scan_row_ext;
   logic [CMP_W-1:0] scan_col_next;
   logic [EXT_W-1:0] count_ext;
   logic             accept;
   logic             req_in_range;
   logic             miss;

   // Effective matrix size: register values above the limit act as the limit.
   always_comb begin
      rows_eff = (CMP_W'(row_count_ff) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
                                                          : CMP_W'(row_count_ff);
      cols_eff = (CMP_W'(col_count_ff) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
                                                          : CMP_W'(col_count_ff);
   end

   assign req_row_ext   = CMP_W'(req_data.row);
   assign req_col_ext   = CMP_W'(req_data.col);
   assign scan_row_ext  = CMP_W'(scan_row_ff);
   assign scan_col_next = CMP_W'(scan_col_ff) + 1'b1;
   assign req_in_range  = (req_row_ext < rows_eff) && (req_col_ext < cols_eff);
   assign count_ext     = EXT_W'(count_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: scan for the position, then shift and insert if needed.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_r_in     = key_r_ff;
      key_c_in     = key_c_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[IW-1:0];
      mem_wdata    = '{val: val_ff, r: key_r_ff, c: key_c_ff};
      mem_raddr    = idx_ff[IW-1:0];
      miss         = 1'b0;

      // The user must issue configuration writes only while idle; the block does not enforce it.
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_in     = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               idx_in    = '0;
               val_in    = req_data.value;
               state_in  = S_DONE;
               case (req_data.kind)
                  KIND_LOAD: begin
                     if (scan_row_ext >= rows_eff) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        key_r_in = scan_row_ext[CW-1:0];
                        key_c_in = scan_col_ff;
                        op_in    = (req_data.value != 32'sd0) ? OP_UPSERT : OP_PROBE;
                        state_in = S_SCAN_RD;
                        if (scan_col_next >= cols_eff) begin
                           scan_col_in = '0;
                           scan_row_in = scan_row_ff + 1'b1;
                        end else begin
                           scan_col_in = scan_col_ff + 1'b1;
                        end
                     end
                  end
                  KIND_READ, KIND_WRITE: begin
                     if (!req_in_range) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        key_r_in = req_row_ext[CW-1:0];
                        key_c_in = req_col_ext[CW-1:0];
                        op_in    = (req_data.kind == KIND_READ) ? OP_READ : OP_UPSERT;
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Issue the read of the next entry, or stop at the end of the table.
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               miss = 1'b1;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end

         // Compare the stored position against the key in row-major order.
         S_SCAN_CMP: begin
            if (rdata_ff.r == key_r_ff && rdata_ff.c == key_c_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
               case (op_ff)
                  OP_READ: rd_in = rdata_ff.val;
                  OP_UPSERT: mem_we = 1'b1;
                  default: ;
               endcase
            end else if ({rdata_ff.r, rdata_ff.c} > {key_r_ff, key_c_ff}) begin
               miss = 1'b1;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end

         // Move entries up by one, from the top down to the insert point.
         S_SHIFT_RD: begin
            mem_raddr = IW'(j_ff - 1'b1);
            state_in  = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = rdata_ff;
            j_in      = IW'(j_ff - 1'b1);
            state_in  = (IW'(j_ff - 1'b1) == pos_ff) ? S_INSERT : S_SHIFT_RD;
         end

         S_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_DONE;
         end

         // Latch the result once the output register is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_value  = rd_ff;
               rsp_in.found       = found_ff;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = count_ext[8:0];
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // No entry at the key: insert for an update unless the table is full, else finish.
      if (miss) begin
         state_in = S_DONE;
         if (op_ff == OP_UPSERT) begin
            if (count_ff == CNT_W'(MAX_ENTRIES)) begin
               status_in = STATUS_FULL;
            end else begin
               pos_in   = idx_ff[IW-1:0];
               j_in     = count_ff[IW-1:0];
               state_in = (count_ff == idx_ff) ? S_INSERT : S_SHIFT_RD;
            end
         end
      end
   end

   // Table memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entry_store_ff[mem_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         row_count_ff <= DIM_RESET;
         col_count_ff <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_r_ff  <= key_r_in;
      key_c_ff  <= key_c_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      j_ff      <= j_in;
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

endmodule
